// ===== rtl/four_lane_byte_hash_defines.svh =====
// assertion macros for the four lane byte hash
// used by modules that carry concurrent checks; expects clk and rst_n in scope
`ifndef FOUR_LANE_BYTE_HASH_DEFINES_SVH
`define FOUR_LANE_BYTE_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define FLBH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("flbh assertion failed");
`define FLBH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flbh assertion failed");
`else
`define FLBH_ASSERT(label, prop)
`define FLBH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/flbh_pkg.sv =====
// package for the four lane byte hash: constants, state type, command struct
// and the constant prime multiply; no dependencies
package flbh_pkg;

    localparam int unsigned LANES      = 4;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned FOLD_SHIFT = 17;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd32;
    localparam logic [63:0] SQUEEZE_MASK   = 64'ha5a5a5a5a5a5a5a5;

    localparam logic [63:0] LANE_INIT [LANES] = '{
        64'hcbf29ce484222325,
        64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1
    };

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SQUEEZE
    } state_t;

    typedef struct packed {
        logic             absorb;
        logic             restart;
        logic             emit;
        logic [IDX_W-1:0] idx;
        logic             last;
    } cmd_t;

    // multiply by 0x100000001b3 mod 2^64 as shifts and adds
    function automatic logic [63:0] mul_prime(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== rtl/flbh_ifs.sv =====
// channel interfaces for the four lane byte hash: input item, result item and
// configuration write; no dependencies
interface flbh_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface flbh_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] hash_byte;
    logic       last_byte;
    modport source (output valid, output hash_byte, output last_byte, input ready);
    modport sink (input valid, input hash_byte, input last_byte, output ready);
endinterface

interface flbh_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/four_lane_byte_hash.sv =====
// four lane byte hash, top level: joins the controller and the datapath to
// the input, result and configuration channels
// depends on flbh_pkg, flbh_ifs, flbh_ctrl and flbh_datapath
//
// in_item carries operation and data_byte. an absorb item (operation 0) mixes
// one byte into the lanes; the next item may follow in the next cycle. a
// finish item (operation 1) emits output_length bytes on out_item (capped at
// MAX_OUTPUT_BYTES), one byte a cycle while the receiver takes them, last_byte
// set on the final one; the finish moves the controller to its squeeze state,
// which writes each byte into the result register, and in_item.ready stays low
// until the squeeze ends. the rate is set by the one byte result register.
// with an output length of zero a finish only restarts the lanes.
// after a finish the lanes return to their initial constants.
// a stalled receiver holds the result register and pauses the squeeze; the
// next item is taken while the final byte still waits.
// cfg writes output_length (reset 32); write only while the block is idle.
// reset (rst_n low, asynchronous) loads the initial lanes, clears the byte
// position and drops out_item.valid.
module four_lane_byte_hash
    import flbh_pkg::*;
#(
    parameter int unsigned MAX_OUTPUT_BYTES = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    flbh_in_if.sink    in_item,
    flbh_out_if.source out_item,
    flbh_cfg_if.sink   cfg
);

    cmd_t cmd;

    flbh_ctrl #(
        .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_item.valid),
        .in_operation (in_item.operation),
        .in_ready     (in_item.ready),
        .out_valid    (out_item.valid),
        .out_ready    (out_item.ready),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .cfg_ready    (cfg.ready),
        .cmd          (cmd)
    );

    flbh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_item.data_byte),
        .hash_byte (out_item.hash_byte),
        .last_byte (out_item.last_byte)
    );

endmodule

// ===== rtl/flbh_datapath.sv =====
// datapath of the four lane byte hash: lanes, byte position and result register
// depends on flbh_pkg
module flbh_datapath
    import flbh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic [7:0] data_byte,
    output logic [7:0] hash_byte,
    output logic       last_byte
);

    logic [63:0] lanes_reg  [LANES];
    logic [63:0] lanes_next [LANES];
    logic [2:0]  pos_reg;
    logic [2:0]  pos_next;
    logic [7:0]  hash_byte_reg;
    logic        last_byte_reg;

    logic [1:0]  cur;
    logic [1:0]  nxt;
    logic [1:0]  ln;
    logic [63:0] mixed;
    logic [63:0] absorbed;
    logic [63:0] squeezed;
    logic [7:0]  emit_byte;

    assign cur       = pos_reg[1:0];
    assign nxt       = cur + 2'd1;
    assign ln        = cmd.idx[1:0];
    assign mixed     = lanes_reg[cur] ^ ({56'd0, data_byte} << {pos_reg, 3'b000});
    assign absorbed  = mul_prime(mixed);
    assign squeezed  = mul_prime(lanes_reg[ln] ^ SQUEEZE_MASK);
    assign emit_byte = lanes_reg[ln][{cmd.idx[2:0], 3'b000} +: 8];

    always_comb
    begin
        lanes_next = lanes_reg;
        pos_next   = pos_reg;
        if (cmd.restart)
        begin
            lanes_next = LANE_INIT;
            pos_next   = '0;
        end
        else if (cmd.absorb)
        begin
            lanes_next[cur] = absorbed;
            lanes_next[nxt] = lanes_reg[nxt] ^ (absorbed >> FOLD_SHIFT);
            pos_next        = pos_reg + 3'd1;
        end
        else if (cmd.emit && cmd.idx[2:0] == 3'd7)
        begin
            // every eighth byte stirs the lane it came from
            lanes_next[ln] = squeezed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg <= LANE_INIT;
            pos_reg   <= '0;
        end
        else
        begin
            lanes_reg <= lanes_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hash_byte_reg <= emit_byte;
            last_byte_reg <= cmd.last;
        end
    end

    assign hash_byte = hash_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

// ===== rtl/flbh_ctrl.sv =====
// controller of the four lane byte hash: state machine, byte counter,
// output length register and result valid; depends on flbh_pkg and the defines
`include "four_lane_byte_hash_defines.svh"
module flbh_ctrl
    import flbh_pkg::*;
#(
    parameter int unsigned MAX_OUTPUT_BYTES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_operation,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic             cfg_valid,
    input  logic [LEN_W-1:0] cfg_data,
    output logic             cfg_ready,
    output cmd_t             cmd
);

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_OUTPUT_BYTES);

    state_t           state_reg;
    state_t           state_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic             in_accept;
    logic             finish;
    logic             slot_free;
    logic             last;
    logic [LEN_W-1:0] capped_len;

    assign in_accept  = in_valid && in_ready;
    assign finish     = in_accept && (in_operation == OP_FINISH);
    assign slot_free  = !out_valid_reg || out_ready;
    assign last       = ({1'b0, idx_reg} + LEN_W'(1)) == count_reg;
    assign capped_len = (len_reg > LEN_CAP) ? LEN_CAP : len_reg;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (finish && capped_len != '0)
                    state_next = ST_SQUEEZE;
            end
            ST_SQUEEZE:
            begin
                if (slot_free && last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.absorb  = 1'b0;
        cmd.restart = 1'b0;
        cmd.emit    = 1'b0;
        cmd.idx     = idx_reg;
        cmd.last    = last;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.absorb  = in_valid && (in_operation == OP_ABSORB);
                cmd.restart = in_valid && (in_operation == OP_FINISH) && capped_len == '0;
            end
            ST_SQUEEZE:
            begin
                cmd.emit    = slot_free;
                cmd.restart = slot_free && last;
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            count_next = capped_len;
            idx_next   = '0;
        end
        else if (cmd.emit)
            idx_next = idx_reg + IDX_W'(1);
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                len_reg <= cfg_data;
        end
    end

    `FLBH_ASSERT(a_no_take_in_squeeze, (state_reg == ST_SQUEEZE) |-> !in_ready)
    `FLBH_ASSERT(a_emit_slot_free, cmd.emit |-> (!out_valid_reg || out_ready))
    `FLBH_ASSERT(a_idx_in_range, (state_reg == ST_SQUEEZE) |-> ({1'b0, idx_reg} < count_reg))
    `FLBH_ASSERT_NEXT(a_last_ends_run, cmd.emit && cmd.last, state_reg == ST_IDLE && out_valid_reg)

endmodule

// ===== sim/four_lane_byte_hash_tb.sv =====
// testbench for four_lane_byte_hash: directed table then random messages,
// every hash byte checked against a lane-level predictor or typed first byte
// held in this file; depends on flbh_pkg, flbh_ifs, four_lane_byte_hash rtl
module four_lane_byte_hash_tb;
    import flbh_pkg::*;

    localparam int unsigned MAX_BYTES  = 64;
    localparam logic [63:0] HASH_PRIME = 64'h100000001b3;
    localparam int RANDOM_ITEMS  = 270;
    localparam int CALM_ITEMS    = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 250;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [7:0] hash_byte;
        logic       last_byte;
    } hash_out_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic       op;
        logic [7:0] value;
        logic       typed;
        logic [7:0] first_hash;
    } row_t;

    // typed first bytes are lane 0 byte 0 of the initial lanes
    localparam int NUM_ROWS = 24;
    localparam row_t DIRECTED [NUM_ROWS] = '{
        '{ROW_ITEM, OP_FINISH, 8'h00, 1'b1, 8'h25},   // empty message, reset length
        '{ROW_CFG,  OP_ABSORB, 8'd1,  1'b0, 8'h00},
        '{ROW_ITEM, OP_FINISH, 8'hff, 1'b1, 8'h25},   // data ignored on finish
        '{ROW_CFG,  OP_ABSORB, 8'd0,  1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'haa, 1'b0, 8'h00},
        '{ROW_ITEM, OP_FINISH, 8'h00, 1'b0, 8'h00},   // zero length still restarts
        '{ROW_CFG,  OP_ABSORB, 8'd4,  1'b0, 8'h00},
        '{ROW_ITEM, OP_FINISH, 8'h00, 1'b1, 8'h25},
        '{ROW_CFG,  OP_ABSORB, 8'd64, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'h00, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'hff, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'h80, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'h01, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'h55, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'haa, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'h7f, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'hfe, 1'b0, 8'h00},
        '{ROW_ITEM, OP_ABSORB, 8'h12, 1'b0, 8'h00},   // position wraps past 7
        '{ROW_ITEM, OP_ABSORB, 8'hc3, 1'b0, 8'h00},
        '{ROW_ITEM, OP_FINISH, 8'h5a, 1'b0, 8'h00},
        '{ROW_CFG,  OP_ABSORB, 8'd127, 1'b0, 8'h00},  // saturates to the cap
        '{ROW_ITEM, OP_FINISH, 8'h00, 1'b1, 8'h25},
        '{ROW_ITEM, OP_ABSORB, 8'hff, 1'b0, 8'h00},
        '{ROW_ITEM, OP_FINISH, 8'h00, 1'b0, 8'h00}
    };

    logic clk;
    logic rst_n;

    flbh_in_if  in_ch ();
    flbh_out_if out_ch ();
    flbh_cfg_if cfg_ch ();

    four_lane_byte_hash #(
        .MAX_OUTPUT_BYTES (MAX_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch),
        .out_item (out_ch),
        .cfg      (cfg_ch)
    );

    logic [63:0] lane_st [LANES];
    logic [2:0]  pos_st;
    logic [6:0]  out_len_st;
    hash_out_t   hash_q [$];

    int items_taken  = 0;
    int failures     = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;
    bit hold_req     = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void restart_lanes();
        for (int k = 0; k < LANES; k++)
        begin
            lane_st[k] = LANE_INIT[k];
        end
        pos_st = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] data);
        logic [1:0] cur;
        logic [1:0] nxt;
        cur = pos_st[1:0];
        nxt = cur + 2'd1;
        lane_st[cur] = (lane_st[cur] ^ (64'(data) << (8 * pos_st))) * HASH_PRIME;
        lane_st[nxt] = lane_st[nxt] ^ (lane_st[cur] >> FOLD_SHIFT);
        pos_st = pos_st + 3'd1;
    endfunction

    // queues the hash bytes of one finish; a typed first byte overrides lane 0
    function automatic void squeeze_lanes(input logic typed, input logic [7:0] first_hash);
        int         count;
        logic [2:0] off;
        logic [1:0] ln;
        hash_out_t  res;
        count = (out_len_st > MAX_BYTES) ? MAX_BYTES : int'(out_len_st);
        for (int j = 0; j < count; j++)
        begin
            off = j[2:0];
            ln  = j[1:0];
            res.hash_byte = (typed && j == 0) ? first_hash : lane_st[ln][8 * off +: 8];
            res.last_byte = (j + 1 == count);
            hash_q.push_back(res);
            if (off == 3'd7)
            begin
                lane_st[ln] = (lane_st[ln] ^ SQUEEZE_MASK) * HASH_PRIME;
            end
        end
        restart_lanes();
    endfunction

    task automatic send_item(input logic op, input logic [7:0] data,
                             input logic typed, input logic [7:0] first_hash);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= data;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_taken++;
        if (op == OP_ABSORB)
            absorb_byte(data);
        else
            squeeze_lanes(typed, first_hash);
    endtask

    // zero-length finishes leave no result to wait on, hence the settle time
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (hash_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [6:0] len);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= len;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        out_len_st = len;
    endtask

    initial
    begin
        int msgs;
        int absorbs;
        int draw;
        int phase;
        int random_start;
        logic [6:0] len;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_ABSORB;
        in_ch.data_byte <= 8'h00;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= LEN_RESET;
        restart_lanes();
        out_len_st = LEN_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_length(DIRECTED[r].value[6:0]);
            else
                send_item(DIRECTED[r].op, DIRECTED[r].value,
                          DIRECTED[r].typed, DIRECTED[r].first_hash);
        end

        phase = 0;
        random_start = items_taken;
        while (items_taken - random_start < RANDOM_ITEMS)
        begin
            draw = $urandom_range(0, 9);
            if (draw == 0)
                len = 7'd0;
            else if (draw == 1)
                len = 7'd64;
            else if (draw == 2)
                len = 7'($urandom_range(65, 127));
            else
                len = 7'($urandom_range(1, 16));
            // long receiver hold with full-length hashes backs up the input
            if (phase == 1)
                len = 7'd64;
            write_length(len);
            if (phase == 1)
                hold_req = 1'b1;
            msgs = $urandom_range(3, 6);
            for (int m = 0; m < msgs; m++)
            begin
                if (phase == 3 && m == 2)
                    drain_results();
                absorbs = $urandom_range(0, 20);
                for (int a = 0; a < absorbs; a++)
                begin
                    send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
                end
                send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
            end
            phase++;
            if (items_taken - random_start >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
        end

        drain_results();
        if (failures == 0)
            $display("four_lane_byte_hash verification clean");
        else
            $display("four_lane_byte_hash verification failed");
        $finish;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        hash_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (hash_q.size() == 0)
            begin
                $error("hash_byte expected none actual %h", out_ch.hash_byte);
                failures++;
            end
            else
            begin
                want = hash_q.pop_front();
                if (want.hash_byte !== out_ch.hash_byte)
                begin
                    $error("hash_byte expected %h actual %h", want.hash_byte, out_ch.hash_byte);
                    failures++;
                end
                if (want.last_byte !== out_ch.last_byte)
                begin
                    $error("last_byte expected %b actual %b", want.last_byte, out_ch.last_byte);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("four_lane_byte_hash verification failed");
            $finish;
        end
    end

endmodule
